FILE: hdl/pdw_pkg.sv
// Shared widths, constants and latencies of the four-point delta weight block.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package pdw_pkg;

	localparam int IN_W          = 20;
	localparam int IN_FRAC_BITS  = 16;
	localparam int Q             = 24;
	localparam int R_W           = Q + 2;
	localparam int D_W           = Q + 1;
	localparam int ARG_W         = 2 * Q + 2;
	localparam int SQ_STAGES     = ARG_W / 2;
	localparam int ROOT_W        = SQ_STAGES;
	localparam int REM_W         = ROOT_W + 1;
	localparam int NUM_W         = Q + 4;
	localparam int F_W           = Q;
	localparam int W_W           = 22;
	localparam int WEIGHT_MAX    = 2097152;
	localparam int LANE_LAT      = 4 + SQ_STAGES + 1;
	localparam int MERGE_LAT     = 4;
	localparam int TOTAL_LAT     = LANE_LAT + MERGE_LAT;
	localparam int AXES          = 3;

endpackage

FILE: hdl/pdw_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on pdw_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module pdw_isqrt (
	input  logic                       clk,
	input  logic [pdw_pkg::ARG_W-1:0]  arg,
	output logic [pdw_pkg::ROOT_W-1:0] root
);

	localparam int STAGES = pdw_pkg::SQ_STAGES;
	localparam int AW     = pdw_pkg::ARG_W;
	localparam int RW     = pdw_pkg::ROOT_W;
	localparam int MW     = pdw_pkg::REM_W;

	logic [AW-1:0] rad_q  [0:STAGES-1];
	logic [MW-1:0] rem_q  [0:STAGES-1];
	logic [RW-1:0] root_q [0:STAGES-1];

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_stage
			logic [AW-1:0] rad_in;
			logic [MW-1:0] rem_in;
			logic [RW-1:0] root_in;
			logic [MW+1:0] cand;
			logic [MW+1:0] trial;
			logic          take;

			if (i == 0) begin : g_first
				assign rad_in  = arg;
				assign rem_in  = '0;
				assign root_in = '0;
			end else begin : g_next
				assign rad_in  = rad_q[i-1];
				assign rem_in  = rem_q[i-1];
				assign root_in = root_q[i-1];
			end

			always_comb begin
				cand  = {rem_in, rad_in[AW-1:AW-2]};
				trial = (MW+2)'({root_in, 2'b01});
				take  = (cand >= trial);
			end

			always_ff @(posedge clk) begin
				rad_q[i] <= rad_in << 2;
				if (take) begin
					rem_q[i]  <= MW'(cand - trial);
					root_q[i] <= {root_in[RW-2:0], 1'b1};
				end else begin
					rem_q[i]  <= MW'(cand);
					root_q[i] <= {root_in[RW-2:0], 1'b0};
				end
			end
		end
	endgenerate

	assign root = root_q[STAGES-1];

endmodule

FILE: hdl/pdw_lane.sv
// One axis lane: magnitude, square-root argument, square root and kernel factor.
// Depends on pdw_pkg and instantiates pdw_isqrt.
`timescale 1ns / 1ps

module pdw_lane #(
	parameter int IN_FRAC_BITS = pdw_pkg::IN_FRAC_BITS
) (
	input  logic                            clk,
	input  logic signed [pdw_pkg::IN_W-1:0] rel,
	output logic [pdw_pkg::F_W-1:0]         factor
);

	localparam int IW     = pdw_pkg::IN_W;
	localparam int QB     = pdw_pkg::Q;
	localparam int RW     = pdw_pkg::R_W;
	localparam int DW     = pdw_pkg::D_W;
	localparam int AW     = pdw_pkg::ARG_W;
	localparam int NW     = pdw_pkg::NUM_W;
	localparam int FW     = pdw_pkg::F_W;
	localparam int STAGES = pdw_pkg::SQ_STAGES;
	localparam int SH     = QB - IN_FRAC_BITS;
	localparam int WIDE_W = IW + QB;

	localparam logic [RW-1:0]        TWO_IN = RW'(2) << IN_FRAC_BITS;
	localparam logic [RW:0]          ONE_Q  = (RW+1)'(1) << QB;
	localparam logic [RW:0]          THR_Q  = (RW+1)'(3) << QB;
	localparam logic [AW-1:0]        TWO_SQ = AW'(2) << (2 * QB);
	localparam logic signed [NW-1:0] NUM3   = NW'(3) << QB;
	localparam logic signed [NW-1:0] NUM5   = NW'(5) << QB;

	logic [IW-1:0]     mag;
	logic [WIDE_W-1:0] wide;
	logic [RW:0]       twor;
	logic [RW:0]       dfull;

	logic [RW-1:0]  r24_s1, r24_s2, r24_s3, r24_s4;
	logic           inner_s1, inner_s2, inner_s3, inner_s4;
	logic           zero_s1, zero_s2, zero_s3, zero_s4;
	logic [DW-1:0]  d_s2;
	logic [AW-1:0]  dd_s3;
	logic [AW-1:0]  arg_s4;

	logic [RW-1:0]  r24_q   [0:STAGES-1];
	logic           inner_q [0:STAGES-1];
	logic           zero_q  [0:STAGES-1];

	logic [pdw_pkg::ROOT_W-1:0] root;
	logic signed [NW-1:0]       num;
	logic signed [NW-1:0]       rnd;
	logic [FW-1:0]              factor_q;

	always_comb begin
		mag  = rel[IW-1] ? (~rel + IW'(1)) : rel;
		wide = WIDE_W'(mag) << SH;
		twor = {r24_s1, 1'b0};
		if (inner_s1) begin
			dfull = (twor >= ONE_Q) ? (twor - ONE_Q) : (ONE_Q - twor);
		end else begin
			dfull = (twor >= THR_Q) ? (twor - THR_Q) : (THR_Q - twor);
		end
		if (dfull > ONE_Q) begin
			dfull = ONE_Q;
		end
	end

	always_ff @(posedge clk) begin
		r24_s1   <= wide[RW-1:0];
		zero_s1  <= (RW'(mag) > TWO_IN);
		inner_s1 <= (wide[RW-1:0] <= ONE_Q[RW-1:0]);

		d_s2     <= dfull[DW-1:0];
		r24_s2   <= r24_s1;
		inner_s2 <= inner_s1;
		zero_s2  <= zero_s1;

		dd_s3    <= AW'(d_s2) * AW'(d_s2);
		r24_s3   <= r24_s2;
		inner_s3 <= inner_s2;
		zero_s3  <= zero_s2;

		arg_s4   <= TWO_SQ - dd_s3;
		r24_s4   <= r24_s3;
		inner_s4 <= inner_s3;
		zero_s4  <= zero_s3;
	end

	always_ff @(posedge clk) begin
		r24_q[0]   <= r24_s4;
		inner_q[0] <= inner_s4;
		zero_q[0]  <= zero_s4;
		for (int k = 1; k < STAGES; k++) begin
			r24_q[k]   <= r24_q[k-1];
			inner_q[k] <= inner_q[k-1];
			zero_q[k]  <= zero_q[k-1];
		end
	end

	pdw_isqrt u_isqrt (
		.clk  (clk),
		.arg  (arg_s4),
		.root (root)
	);

	always_comb begin
		if (inner_q[STAGES-1]) begin
			num = NUM3 - $signed(NW'({r24_q[STAGES-1], 1'b0})) + $signed(NW'(root));
		end else begin
			num = NUM5 - $signed(NW'({r24_q[STAGES-1], 1'b0})) - $signed(NW'(root));
		end
		rnd = (num + NW'(4)) >>> 3;
	end

	always_ff @(posedge clk) begin
		if (zero_q[STAGES-1] || num[NW-1]) begin
			factor_q <= '0;
		end else begin
			factor_q <= rnd[FW-1:0];
		end
	end

	assign factor = factor_q;

endmodule

FILE: hdl/pdw_merge.sv
// Merging stage: multiplies the three axis factors with rounding and saturation.
// Depends on pdw_pkg for the factor and weight widths.
`timescale 1ns / 1ps

module pdw_merge (
	input  logic                     clk,
	input  logic [pdw_pkg::F_W-1:0]  fx,
	input  logic [pdw_pkg::F_W-1:0]  fy,
	input  logic [pdw_pkg::F_W-1:0]  fz,
	output logic [pdw_pkg::W_W-1:0]  weight
);

	localparam int FW = pdw_pkg::F_W;
	localparam int QB = pdw_pkg::Q;
	localparam int PW = 2 * FW;
	localparam int RW = FW - 1;
	localparam int WW = pdw_pkg::W_W;

	localparam logic [PW-1:0] HALF = PW'(1) << (QB - 1);
	localparam logic [PW-1:0] WMAX = PW'(pdw_pkg::WEIGHT_MAX);

	logic [PW-1:0] p1_s1;
	logic [FW-1:0] fz_s1;
	logic [RW-1:0] p1r_s2;
	logic [FW-1:0] fz_s2;
	logic [PW-1:0] p2_s3;
	logic [WW-1:0] weight_s4;
	logic [PW-1:0] sum1;
	logic [PW-1:0] sum2;

	always_comb begin
		sum1 = (p1_s1 + HALF) >> QB;
		sum2 = (p2_s3 + HALF) >> QB;
	end

	always_ff @(posedge clk) begin
		p1_s1  <= PW'(fx) * PW'(fy);
		fz_s1  <= fz;
		p1r_s2 <= sum1[RW-1:0];
		fz_s2  <= fz_s1;
		p2_s3  <= PW'(p1r_s2) * PW'(fz_s2);
		if (sum2 > WMAX) begin
			weight_s4 <= WMAX[WW-1:0];
		end else begin
			weight_s4 <= sum2[WW-1:0];
		end
	end

	assign weight = weight_s4;

endmodule

FILE: hdl/peskin_delta_weight.sv
// Four-point delta kernel weight: from start to done, the data passes in each axis
// lane through four argument stages, the 25-stage square root and the factor register, then 4 merge stages.
// Throughput is one transaction per cycle; busy is held low and done strobes once
// per transaction, since the receiver cannot stall.
// Reset clears only the valid pipeline; data registers are not reset.
// Depends on pdw_pkg, pdw_lane and pdw_merge.
`timescale 1ns / 1ps

module peskin_delta_weight #(
	parameter int IN_FRAC_BITS = pdw_pkg::IN_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [pdw_pkg::IN_W-1:0] rel_x,
	input  logic signed [pdw_pkg::IN_W-1:0] rel_y,
	input  logic signed [pdw_pkg::IN_W-1:0] rel_z,
	output logic                            done,
	output logic [pdw_pkg::W_W-1:0]         weight
);

	localparam int LAT = pdw_pkg::TOTAL_LAT;

	logic signed [pdw_pkg::IN_W-1:0] rel_in [0:pdw_pkg::AXES-1];
	logic [pdw_pkg::F_W-1:0]         fac    [0:pdw_pkg::AXES-1];
	logic [LAT-1:0]                  vld_q;

	assign rel_in[0] = rel_x;
	assign rel_in[1] = rel_y;
	assign rel_in[2] = rel_z;
	assign busy      = 1'b0;

	genvar a;
	generate
		for (a = 0; a < pdw_pkg::AXES; a++) begin : g_lane
			pdw_lane #(
				.IN_FRAC_BITS (IN_FRAC_BITS)
			) u_lane (
				.clk    (clk),
				.rel    (rel_in[a]),
				.factor (fac[a])
			);
		end
	endgenerate

	pdw_merge u_merge (
		.clk    (clk),
		.fx     (fac[0]),
		.fy     (fac[1]),
		.fz     (fac[2]),
		.weight (weight)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

endmodule

FILE: dv/tb.sv
// Self-checking testbench for peskin_delta_weight: random and directed offsets go in,
// and every weight that comes out is checked against a kernel weight computed here.
// Depends on pdw_pkg and the RTL of peskin_delta_weight.
`timescale 1ns / 1ps

module tb;

	localparam int W_W       = pdw_pkg::W_W;
	localparam int IN_W      = pdw_pkg::IN_W;
	localparam int FRAC      = pdw_pkg::IN_FRAC_BITS;
	localparam int Q         = pdw_pkg::Q;
	localparam int N_RANDOM  = 1400;
	localparam int TAIL      = pdw_pkg::TOTAL_LAT + 16;
	localparam int LIMIT     = 400000;

	typedef struct {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
		int unsigned            gap;
		bit                     drain;
	} site_t;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start  = 1'b0;
	logic signed [IN_W-1:0] rel_x  = '0;
	logic signed [IN_W-1:0] rel_y  = '0;
	logic signed [IN_W-1:0] rel_z  = '0;
	logic                   busy;
	logic                   done;
	logic [W_W-1:0]         weight;

	site_t          offset_q[$];
	logic [W_W-1:0] weight_q[$];
	int             mismatches = 0;
	int             cycles     = 0;

	peskin_delta_weight u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.rel_x  (rel_x),
		.rel_y  (rel_y),
		.rel_z  (rel_z),
		.done   (done),
		.weight (weight)
	);

	always #5 clk = ~clk;

	function automatic longint root_floor(longint v);
		longint root;
		longint trial;
		root = 0;
		for (int i = 25; i >= 0; i--) begin
			trial = root | (longint'(1) << i);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// One axis of the four-point kernel, Q.24, rounded half up.
	function automatic longint peskin_factor(logic signed [IN_W-1:0] pos);
		longint one;
		longint s;
		longint mag;
		longint r;
		longint c;
		longint d;
		longint sq;
		longint num;
		bit     inner;
		one = longint'(1) << Q;
		s   = pos;
		mag = (s < 0) ? -s : s;
		if (mag > (longint'(2) << FRAC))
			return 0;
		r     = mag << (Q - FRAC);
		inner = (r <= one);
		c     = inner ? one : 3 * one;
		d     = (2 * r >= c) ? 2 * r - c : c - 2 * r;
		if (d > one)
			d = one;
		sq = root_floor((longint'(2) << 48) - d * d);
		if (inner)
			num = 3 * one - 2 * r + sq;
		else
			num = 5 * one - 2 * r - sq;
		if (num < 0)
			num = 0;
		return (num + 4) >> 3;
	endfunction

	function automatic logic [W_W-1:0] delta_weight(logic signed [IN_W-1:0] x,
			logic signed [IN_W-1:0] y, logic signed [IN_W-1:0] z);
		longint p;
		p = (peskin_factor(x) * peskin_factor(y) + (longint'(1) << 23)) >> 24;
		p = (p * peskin_factor(z) + (longint'(1) << 23)) >> 24;
		if (p > pdw_pkg::WEIGHT_MAX)
			p = pdw_pkg::WEIGHT_MAX;
		return p[W_W-1:0];
	endfunction

	function automatic logic signed [IN_W-1:0] pick_offset();
		int unsigned sel;
		int          v;
		sel = $urandom_range(99);
		if (sel < 65) begin
			v = int'($urandom_range(262144)) - 131072;
		end else if (sel < 77) begin
			v = ($urandom_range(1) ? 65536 : 131072) + int'($urandom_range(16)) - 8;
			if ($urandom_range(1))
				v = -v;
		end else if (sel < 89) begin
			v = int'($urandom());
		end else begin
			case ($urandom_range(8))
				0: v = 0;
				1: v = -524288;
				2: v = 524287;
				3: v = 65536;
				4: v = -65536;
				5: v = 131072;
				6: v = -131072;
				7: v = 1;
				default: v = -1;
			endcase
		end
		return v[IN_W-1:0];
	endfunction

	task automatic add_site(int x, int y, int z, int unsigned gap, bit drain);
		site_t s;
		s.x     = x[IN_W-1:0];
		s.y     = y[IN_W-1:0];
		s.z     = z[IN_W-1:0];
		s.gap   = gap;
		s.drain = drain;
		offset_q.push_back(s);
	endtask

	task automatic report(string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Stimulus source.
	always @(posedge clk or negedge arst_n) begin : driver
		site_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			rel_x <= '0;
			rel_y <= '0;
			rel_z <= '0;
		end else begin
			if (start && !busy)
				weight_q.push_back(delta_weight(rel_x, rel_y, rel_z));
			if (!(start && busy)) begin
				if (offset_q.size() == 0) begin
					start <= 1'b0;
				end else if (offset_q[0].gap != 0) begin
					offset_q[0].gap = offset_q[0].gap - 1;
					start <= 1'b0;
				end else if (offset_q[0].drain && weight_q.size() != 0) begin
					start <= 1'b0;
				end else begin
					nxt = offset_q.pop_front();
					rel_x <= nxt.x;
					rel_y <= nxt.y;
					rel_z <= nxt.z;
					start <= 1'b1;
				end
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin : monitor
		logic [W_W-1:0] want;
		if (arst_n && done === 1'b1) begin
			if (weight_q.size() == 0) begin
				report($sformatf("weight %0d with no transaction outstanding", weight));
			end else begin
				want = weight_q.pop_front();
				if (weight !== want)
					report($sformatf("weight %0d, expected %0d", weight, want));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		bit          burst;
		add_site(0, 0, 0, 0, 1'b0);
		add_site(65536, 65536, 65536, 0, 1'b0);
		add_site(-65536, -65536, -65536, 0, 1'b0);
		add_site(131072, -131072, 0, 0, 1'b0);
		add_site(131071, 131073, 0, 0, 1'b0);
		add_site(65535, 65537, -65537, 1, 1'b0);
		add_site(-524288, 0, 0, 0, 1'b0);
		add_site(524287, 0, 0, 0, 1'b0);
		add_site(0, -524288, 524287, 0, 1'b0);
		add_site(1, -1, 0, 0, 1'b0);
		add_site(-131071, 131071, -1, 2, 1'b0);
		add_site(32768, -98304, 16384, 0, 1'b0);
		add_site(0, 0, 131072, 0, 1'b0);
		add_site(0, 0, 131073, 0, 1'b0);
		add_site(-131073, 0, 0, 0, 1'b0);
		add_site(-262144, 262143, 0, 0, 1'b0);
		add_site(98304, 98304, 98304, 3, 1'b0);
		add_site(-1, -1, -1, 0, 1'b0);
		add_site(65536, 0, -65536, 0, 1'b0);
		add_site(131072, 131072, 131072, 0, 1'b0);

		burst = 1'b0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0)
				burst = ($urandom_range(2) == 0);
			if (burst) begin
				gap = 0;
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: gap = 0;
					6, 7, 8:          gap = $urandom_range(3, 1);
					default:          gap = $urandom_range(50, 5);
				endcase
			end
			add_site(pick_offset(), pick_offset(), pick_offset(), gap, i % 350 == 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (offset_q.size() != 0 || start)
			@(posedge clk);
		while (weight_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
